// ----- sv/iss_pkg.sv -----
// Package for the IMU sample scale and remap block.
// Holds axis types, scale constants and the mounting layout decode.
// No dependencies.
package iss_pkg;

  localparam int unsigned NumAxes = 3;

  typedef logic signed [15:0] raw_t;
  typedef logic signed [24:0] acc_t;
  typedef logic signed [22:0] rate_t;

  typedef raw_t  raw_vec_t  [NumAxes];
  typedef acc_t  acc_vec_t  [NumAxes];
  typedef rate_t rate_vec_t [NumAxes];

  // 9.807 * 2^16 and (pi / 180) * 2^16, rounded to nearest.
  localparam logic signed [20:0] AccScale = 21'sd642712;
  localparam logic signed [11:0] GyrScale = 12'sd1144;

  // Shift is the base minus the range code.
  localparam logic [3:0] AccShiftBase = 4'd14;
  localparam logic [3:0] GyrShiftBase = 4'd11;

  localparam logic [1:0] AccRangeReset = 2'd2;
  localparam logic [2:0] GyrRangeReset = 3'd6;
  localparam logic [2:0] LayoutReset   = 3'd0;

  // Configuration register indexes.
  localparam logic [1:0] RegAccRange = 2'd0;
  localparam logic [1:0] RegGyrRange = 2'd1;
  localparam logic [1:0] RegLayout   = 2'd2;

  // Status bits that mark a ready sample.
  localparam int unsigned StatAccRdy = 0;
  localparam int unsigned StatGyrRdy = 1;

  typedef struct packed {
    logic neg_z;
    logic swap_xy;
    logic neg_x;
    logic neg_y;
  } remap_ctl_t;

  function automatic remap_ctl_t layout_decode(logic [2:0] layout);
    remap_ctl_t ctl;
    ctl.neg_z   = layout[2];
    ctl.swap_xy = layout[0];
    unique case (layout)
      3'd0: begin ctl.neg_x = 1'b0; ctl.neg_y = 1'b0; end
      3'd1: begin ctl.neg_x = 1'b1; ctl.neg_y = 1'b0; end
      3'd2: begin ctl.neg_x = 1'b1; ctl.neg_y = 1'b1; end
      3'd3: begin ctl.neg_x = 1'b0; ctl.neg_y = 1'b1; end
      3'd4: begin ctl.neg_x = 1'b1; ctl.neg_y = 1'b0; end
      3'd5: begin ctl.neg_x = 1'b0; ctl.neg_y = 1'b0; end
      3'd6: begin ctl.neg_x = 1'b0; ctl.neg_y = 1'b1; end
      default: begin ctl.neg_x = 1'b1; ctl.neg_y = 1'b1; end
    endcase
    return ctl;
  endfunction

endpackage

// ----- sv/iss_if.sv -----
// Valid/ready channel interfaces for raw samples and converted results.
// Depends on iss_pkg for the axis types.
interface iss_smp_if
  import iss_pkg::*;
();
  logic valid;
  logic ready;
  logic [7:0] status_byte;
  raw_t raw_accel_x;
  raw_t raw_accel_y;
  raw_t raw_accel_z;
  raw_t raw_gyro_x;
  raw_t raw_gyro_y;
  raw_t raw_gyro_z;

  modport source (
    output valid, status_byte, raw_accel_x, raw_accel_y, raw_accel_z,
    output raw_gyro_x, raw_gyro_y, raw_gyro_z,
    input  ready
  );
  modport sink (
    input  valid, status_byte, raw_accel_x, raw_accel_y, raw_accel_z,
    input  raw_gyro_x, raw_gyro_y, raw_gyro_z,
    output ready
  );
endinterface

interface iss_res_if
  import iss_pkg::*;
();
  logic valid;
  logic ready;
  logic fresh;
  acc_t  accel_x;
  acc_t  accel_y;
  acc_t  accel_z;
  rate_t rate_x;
  rate_t rate_y;
  rate_t rate_z;

  modport source (
    output valid, fresh, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, fresh, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

// ----- sv/imu_sample_scale_and_remap_top.sv -----
// Top level of the IMU sample scale and remap block.
// Depends on iss_pkg, iss_if, iss_scale and iss_remap.
//
// The block takes one sample request per cycle while its input is not
// stalled and returns one result per sample, passing through the input
// register and then the result register, with the constant multiply, range
// shift and orientation remap between them. A sample whose
// status has both the accel-ready and gyro-ready bits set is converted to
// Q.16 m/s^2 and rad/s, remapped for the mounting layout and stored; the
// result then carries fresh = 1. Any other sample returns the stored values
// with fresh = 0. The stored values are zero after reset. Configuration
// (accel range, gyro range, mounting layout) is written through the plain
// write port and must only change while no sample is in flight.
module imu_sample_scale_and_remap_top
  import iss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [2:0] cfg_data_i,
  iss_smp_if.sink    smp_i,
  iss_res_if.source  res_o
);

  // Configuration registers.
  logic [1:0] acc_range_q;
  logic [2:0] gyr_range_q, layout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_range_q <= AccRangeReset;
      gyr_range_q <= GyrRangeReset;
      layout_q    <= LayoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAccRange: acc_range_q <= cfg_data_i[1:0];
        RegGyrRange: gyr_range_q <= cfg_data_i;
        RegLayout:   layout_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register stage. Only the combined ready flag of the status is kept.
  logic     s1_valid_q, s1_valid_d;
  logic     s1_fresh_q;
  raw_vec_t s1_acc_q, s1_gyr_q;
  logic     s1_accept;

  // Result register stage. The held store doubles as the result payload,
  // since a result always shows the store as it stands after its sample.
  logic      out_valid_q, out_valid_d;
  logic      fresh_q;
  acc_vec_t  held_acc_q;
  rate_vec_t held_rate_q;
  logic      s2_ready, s2_load;

  assign s2_ready    = !out_valid_q || res_o.ready;
  assign s2_load     = s1_valid_q && s2_ready;
  assign smp_i.ready = !s1_valid_q || s2_ready;
  assign s1_accept   = smp_i.valid && smp_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_accept) begin
      s1_fresh_q  <= smp_i.status_byte[StatAccRdy] && smp_i.status_byte[StatGyrRdy];
      s1_acc_q[0] <= smp_i.raw_accel_x;
      s1_acc_q[1] <= smp_i.raw_accel_y;
      s1_acc_q[2] <= smp_i.raw_accel_z;
      s1_gyr_q[0] <= smp_i.raw_gyro_x;
      s1_gyr_q[1] <= smp_i.raw_gyro_y;
      s1_gyr_q[2] <= smp_i.raw_gyro_z;
    end
  end

  // Conversion path between the two register stages.
  acc_vec_t   acc_scaled, acc_mapped;
  rate_vec_t  rate_scaled, rate_mapped;
  remap_ctl_t remap_ctl;

  assign remap_ctl = layout_decode(layout_q);

  iss_scale u_scale (
    .acc_raw_i   (s1_acc_q),
    .gyr_raw_i   (s1_gyr_q),
    .acc_range_i (acc_range_q),
    .gyr_range_i (gyr_range_q),
    .acc_o       (acc_scaled),
    .rate_o      (rate_scaled)
  );

  iss_remap u_remap (
    .acc_i  (acc_scaled),
    .rate_i (rate_scaled),
    .ctl_i  (remap_ctl),
    .acc_o  (acc_mapped),
    .rate_o (rate_mapped)
  );

  // The store is state of the block and resets to zero; it only takes new
  // values from a fresh sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        held_acc_q[i]  <= '0;
        held_rate_q[i] <= '0;
      end
    end else if (s2_load) begin
      fresh_q <= s1_fresh_q;
      if (s1_fresh_q) begin
        held_acc_q  <= acc_mapped;
        held_rate_q <= rate_mapped;
      end
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.fresh   = fresh_q;
  assign res_o.accel_x = held_acc_q[0];
  assign res_o.accel_y = held_acc_q[1];
  assign res_o.accel_z = held_acc_q[2];
  assign res_o.rate_x  = held_rate_q[0];
  assign res_o.rate_y  = held_rate_q[1];
  assign res_o.rate_z  = held_rate_q[2];

`ifndef SYNTH
  // The store changes only when a sample moves into the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_load |=> $stable(held_acc_q[0]) && $stable(held_acc_q[1]) &&
                 $stable(held_acc_q[2]) && $stable(held_rate_q[0]) &&
                 $stable(held_rate_q[1]) && $stable(held_rate_q[2]))
    else $error("held store changed without a result load");

  // A sample that is not ready leaves the store as it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load && !s1_fresh_q |=> $stable(held_acc_q[0]) && $stable(held_acc_q[1]) &&
                               $stable(held_acc_q[2]) && $stable(held_rate_q[0]) &&
                               $stable(held_rate_q[1]) && $stable(held_rate_q[2]))
    else $error("stale sample overwrote the held store");

  // Input backpressure only when both stages are full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !smp_i.ready |-> s1_valid_q && out_valid_q && !res_o.ready)
    else $error("input stalled while a stage was free");

  // A loaded result is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> res_o.valid)
    else $error("loaded result not presented");
`endif

endmodule

// ----- sv/iss_scale.sv -----
// Fixed-point scaling of three accel and three gyro axes.
// Depends on iss_pkg for types and scale constants.
module iss_scale
  import iss_pkg::*;
(
  input  raw_vec_t   acc_raw_i,
  input  raw_vec_t   gyr_raw_i,
  input  logic [1:0] acc_range_i,
  input  logic [2:0] gyr_range_i,
  output acc_vec_t   acc_o,
  output rate_vec_t  rate_o
);

  logic [3:0] acc_sh;
  logic [3:0] gyr_sh;
  logic signed [36:0] acc_prod [NumAxes];
  logic signed [36:0] acc_shr  [NumAxes];
  logic signed [27:0] gyr_prod [NumAxes];
  logic signed [27:0] gyr_shr  [NumAxes];

  assign acc_sh = AccShiftBase - {2'b00, acc_range_i};
  assign gyr_sh = GyrShiftBase - {1'b0, gyr_range_i};

  // Constant multiply, then floor shift by the range sensitivity.
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      acc_prod[i] = 37'(acc_raw_i[i]) * 37'(AccScale);
      acc_shr[i]  = acc_prod[i] >>> acc_sh;
      acc_o[i]    = acc_shr[i][24:0];
      gyr_prod[i] = 28'(gyr_raw_i[i]) * 28'(GyrScale);
      gyr_shr[i]  = gyr_prod[i] >>> gyr_sh;
      rate_o[i]   = gyr_shr[i][22:0];
    end
  end

endmodule

// ----- sv/iss_remap.sv -----
// Mounting orientation remap: optional x/y swap and per-axis negation.
// Depends on iss_pkg for types and the remap control struct.
module iss_remap
  import iss_pkg::*;
(
  input  acc_vec_t   acc_i,
  input  rate_vec_t  rate_i,
  input  remap_ctl_t ctl_i,
  output acc_vec_t   acc_o,
  output rate_vec_t  rate_o
);

  acc_t  acc_x, acc_y;
  rate_t rate_x, rate_y;

  always_comb begin
    acc_x  = ctl_i.swap_xy ? acc_i[1]  : acc_i[0];
    acc_y  = ctl_i.swap_xy ? acc_i[0]  : acc_i[1];
    rate_x = ctl_i.swap_xy ? rate_i[1] : rate_i[0];
    rate_y = ctl_i.swap_xy ? rate_i[0] : rate_i[1];

    acc_o[0]  = ctl_i.neg_x ? -acc_x  : acc_x;
    acc_o[1]  = ctl_i.neg_y ? -acc_y  : acc_y;
    acc_o[2]  = ctl_i.neg_z ? -acc_i[2] : acc_i[2];
    rate_o[0] = ctl_i.neg_x ? -rate_x : rate_x;
    rate_o[1] = ctl_i.neg_y ? -rate_y : rate_y;
    rate_o[2] = ctl_i.neg_z ? -rate_i[2] : rate_i[2];
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the IMU sample scale and remap block.
// Depends on iss_pkg, iss_if and imu_sample_scale_and_remap_top.
module tb_top
  import iss_pkg::*;
();

  // Index 3 of the write port selects no register and must be ignored.
  localparam logic [1:0] RegUnused = 2'd3;

  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 250;
  localparam int LongHold    = 80;
  localparam int DrainCycles = 6;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [7:0] status;
    raw_t       ax;
    raw_t       ay;
    raw_t       az;
    raw_t       gx;
    raw_t       gy;
    raw_t       gz;
  } sample_t;

  typedef struct packed {
    logic  fresh;
    acc_t  accel_x;
    acc_t  accel_y;
    acc_t  accel_z;
    rate_t rate_x;
    rate_t rate_y;
    rate_t rate_z;
  } result_t;

  // Wide working copy of one triplet, so that scaling and negation never wrap.
  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } axes_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] idx;
    logic [2:0] data;
    sample_t    smp;
    bit         typed;
    result_t    want;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [2:0] cfg_data_i;

  iss_smp_if smp ();
  iss_res_if res ();

  imu_sample_scale_and_remap_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp),
    .res_o      (res)
  );

  // Shadow copy of the configuration and of the stored values.
  logic [1:0] acc_range_q = AccRangeReset;
  logic [2:0] gyr_range_q = GyrRangeReset;
  logic [2:0] layout_q    = LayoutReset;
  result_t    held_q      = '0;

  result_t pending_results [$];
  row_t    directed [$];
  int      mismatches = 0;
  int      cycle_cnt  = 0;
  bit      calm       = 1'b0;
  bit      hold_req   = 1'b0;
  result_t got_q;
  result_t want_q;

  always #1 clk_i = ~clk_i;

  // The watchdog ends a run that hangs on a lost handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Applies the mounting layout: z flips for the upper four layouts, odd
  // layouts swap x and y, and then x and y flip by layout.
  function automatic axes_t orient_axes(axes_t v, logic [2:0] lay);
    longint t;
    if (lay[2]) v.z = -v.z;
    if (lay[0]) begin
      t   = v.x;
      v.x = v.y;
      v.y = t;
    end
    case (lay) inside
      3'd1, 3'd2, 3'd4, 3'd7: v.x = -v.x;
      default: ;
    endcase
    case (lay) inside
      3'd2, 3'd3, 3'd6, 3'd7: v.y = -v.y;
      default: ;
    endcase
    return v;
  endfunction

  // Predicts the result of one sample and updates the stored values when
  // both ready bits are set. The right shifts are arithmetic, so they floor.
  function automatic result_t convert_sample(sample_t s);
    axes_t   a;
    axes_t   g;
    int      ash;
    int      gsh;
    result_t r;
    ash = int'(AccShiftBase) - int'(acc_range_q);
    gsh = int'(GyrShiftBase) - int'(gyr_range_q);
    if (s.status[StatAccRdy] && s.status[StatGyrRdy]) begin
      a.x = (longint'(s.ax) * longint'(AccScale)) >>> ash;
      a.y = (longint'(s.ay) * longint'(AccScale)) >>> ash;
      a.z = (longint'(s.az) * longint'(AccScale)) >>> ash;
      g.x = (longint'(s.gx) * longint'(GyrScale)) >>> gsh;
      g.y = (longint'(s.gy) * longint'(GyrScale)) >>> gsh;
      g.z = (longint'(s.gz) * longint'(GyrScale)) >>> gsh;
      a = orient_axes(a, layout_q);
      g = orient_axes(g, layout_q);
      held_q.accel_x = acc_t'(a.x);
      held_q.accel_y = acc_t'(a.y);
      held_q.accel_z = acc_t'(a.z);
      held_q.rate_x  = rate_t'(g.x);
      held_q.rate_y  = rate_t'(g.y);
      held_q.rate_z  = rate_t'(g.z);
      r = held_q;
      r.fresh = 1'b1;
    end else begin
      r = held_q;
      r.fresh = 1'b0;
    end
    return r;
  endfunction

  function automatic sample_t mk_sample(logic [7:0] st, raw_t ax, raw_t ay, raw_t az,
                                        raw_t gx, raw_t gy, raw_t gz);
    sample_t s;
    s.status = st;
    s.ax = ax;
    s.ay = ay;
    s.az = az;
    s.gx = gx;
    s.gy = gy;
    s.gz = gz;
    return s;
  endfunction

  function automatic result_t mk_result(logic fr, acc_t a, rate_t g);
    result_t r;
    r.fresh   = fr;
    r.accel_x = a;
    r.accel_y = a;
    r.accel_z = a;
    r.rate_x  = g;
    r.rate_y  = g;
    r.rate_z  = g;
    return r;
  endfunction

  function automatic void add_sample(sample_t s);
    row_t r;
    r = '{kind: RowSample, idx: '0, data: '0, smp: s, typed: 1'b0, want: '0};
    directed.push_back(r);
  endfunction

  function automatic void add_typed(sample_t s, result_t w);
    row_t r;
    r = '{kind: RowSample, idx: '0, data: '0, smp: s, typed: 1'b1, want: w};
    directed.push_back(r);
  endfunction

  function automatic void add_write(logic [1:0] idx, logic [2:0] data);
    row_t r;
    r = '{kind: RowWrite, idx: idx, data: data, smp: '0, typed: 1'b0, want: '0};
    directed.push_back(r);
  endfunction

  // Extremes and the values around zero come up far more often than a
  // uniform draw would give them.
  function automatic raw_t pick_raw();
    case ($urandom_range(0, 9))
      0: return raw_t'(-32768);
      1: return raw_t'(32767);
      2: return raw_t'(0);
      3: return raw_t'(-1);
      default: return raw_t'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one request and waits for it to be taken. The expectation is
  // queued at the accepting edge; a typed-in expectation replaces the
  // prediction, but the prediction still advances the stored values.
  task automatic send_request(sample_t s, bit typed, result_t want);
    result_t model;
    smp.valid       <= 1'b1;
    smp.status_byte <= s.status;
    smp.raw_accel_x <= s.ax;
    smp.raw_accel_y <= s.ay;
    smp.raw_accel_z <= s.az;
    smp.raw_gyro_x  <= s.gx;
    smp.raw_gyro_y  <= s.gy;
    smp.raw_gyro_z  <= s.gz;
    do @(posedge clk_i); while (!smp.ready);
    model = convert_sample(s);
    pending_results.push_back(typed ? want : model);
  endtask

  // Random sender gap with valid dropped, except in the calm phase.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stops offering requests until every expected result has come back, then
  // lets the pipeline settle.
  task automatic drain();
    smp.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register writes only happen with the block empty. The shadow copy masks
  // the value the same way the block does.
  task automatic write_reg(logic [1:0] idx, logic [2:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegAccRange: acc_range_q = data[1:0];
      RegGyrRange: gyr_range_q = data;
      RegLayout:   layout_q    = data;
      default: ;
    endcase
  endtask

  // Receiver: random stall bursts, one long hold-off on request from the
  // stimulus, and no stalls at all once the calm phase starts.
  initial begin
    res.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Every result taken is compared field by field with the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      got_q = '{fresh: res.fresh, accel_x: res.accel_x, accel_y: res.accel_y,
                accel_z: res.accel_z, rate_x: res.rate_x, rate_y: res.rate_y,
                rate_z: res.rate_z};
      if (pending_results.size() == 0) begin
        $error("result with no request pending: fresh %0d", got_q.fresh);
        mismatches++;
      end else begin
        want_q = pending_results.pop_front();
        check_field("fresh",   want_q.fresh,   got_q.fresh);
        check_field("accel_x", want_q.accel_x, got_q.accel_x);
        check_field("accel_y", want_q.accel_y, got_q.accel_y);
        check_field("accel_z", want_q.accel_z, got_q.accel_z);
        check_field("rate_x",  want_q.rate_x,  got_q.rate_x);
        check_field("rate_y",  want_q.rate_y,  got_q.rate_y);
        check_field("rate_z",  want_q.rate_z,  got_q.rate_z);
      end
    end
  end

  // Stimulus: a directed table first, then random phases, each with its own
  // configuration.
  initial begin
    sample_t s;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    smp.valid       = 1'b0;
    smp.status_byte = '0;
    smp.raw_accel_x = '0;
    smp.raw_accel_y = '0;
    smp.raw_accel_z = '0;
    smp.raw_gyro_x  = '0;
    smp.raw_gyro_y  = '0;
    smp.raw_gyro_z  = '0;

    // Before any fresh sample the stored values are the reset zeros, and a
    // sample with either ready bit clear, or only the other status bits
    // set, returns them with fresh low.
    add_typed(mk_sample(8'h00, 32767, 32767, 32767, 32767, 32767, 32767),
              mk_result(1'b0, '0, '0));
    add_typed(mk_sample(8'h01, -32768, -32768, -32768, -32768, -32768, -32768),
              mk_result(1'b0, '0, '0));
    add_typed(mk_sample(8'h02, 1, 2, 3, 4, 5, 6), mk_result(1'b0, '0, '0));
    add_typed(mk_sample(8'hFC, -1, -1, -1, -1, -1, -1), mk_result(1'b0, '0, '0));
    add_typed(mk_sample(8'h03, 0, 0, 0, 0, 0, 0), mk_result(1'b1, '0, '0));
    // Reset ranges at both ends of the raw scale, and a held repeat between.
    add_sample(mk_sample(8'hFF, 32767, 32767, 32767, 32767, 32767, 32767));
    add_sample(mk_sample(8'h00, 0, 0, 0, 0, 0, 0));
    add_sample(mk_sample(8'h03, -32768, -32768, -32768, -32768, -32768, -32768));
    // Widest ranges: the most negative raw value gives the output extremes.
    add_write(RegAccRange, 3'd3);
    add_write(RegGyrRange, 3'd7);
    add_typed(mk_sample(8'h03, -32768, -32768, -32768, -32768, -32768, -32768),
              mk_result(1'b1, -25'sd10283392, -23'sd2342912));
    add_sample(mk_sample(8'h03, 32767, 32767, 32767, 32767, 32767, 32767));
    // Narrowest ranges; the accel range value has its upper bit masked off.
    add_write(RegAccRange, 3'd4);
    add_write(RegGyrRange, 3'd0);
    add_sample(mk_sample(8'h03, -1, -1, -1, -1, -1, -1));
    add_sample(mk_sample(8'h03, 32767, 32767, 32767, 32767, 32767, 32767));
    // A write to the unused index must leave every register alone.
    add_write(RegUnused, 3'd5);
    add_sample(mk_sample(8'h07, 1, -2, 3, -4, 5, -6));
    // Every mounting layout with distinct values on each axis.
    for (int lay = 0; lay < 8; lay++) begin
      add_write(RegLayout, 3'(lay));
      add_sample(mk_sample(8'h03, raw_t'(1000 + lay), -2000, 3000, -400, 500, -600));
    end
    add_sample(mk_sample(8'h01, 7, 7, 7, 7, 7, 7));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == RowWrite) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_request(directed[i].smp, directed[i].typed, directed[i].want);
        sender_gap();
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      // The first two phases take the narrowest and widest settings, the
      // rest random ones; the raw draw keeps the upper data bit toggling.
      if (ph == 0) begin
        write_reg(RegAccRange, 3'd0);
        write_reg(RegGyrRange, 3'd0);
        write_reg(RegLayout, 3'd0);
      end else if (ph == 1) begin
        write_reg(RegAccRange, 3'd7);
        write_reg(RegGyrRange, 3'd7);
        write_reg(RegLayout, 3'd7);
      end else begin
        write_reg(RegAccRange, 3'($urandom_range(0, 7)));
        write_reg(RegGyrRange, 3'($urandom_range(0, 7)));
        write_reg(RegLayout, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 0) write_reg(RegUnused, 3'($urandom_range(0, 7)));
      end
      if (ph == NumPhases - 1) calm = 1'b1;

      for (int n = 0; n < PhaseItems; n++) begin
        // The receiver holds off for a long stretch while requests keep
        // coming, so the block fills up and stalls its input.
        if (ph == 3 && n == 50) hold_req = 1'b1;
        // Halfway through one phase the sender waits for the block to empty.
        if (ph == 5 && n == PhaseItems / 2) drain();
        // Mostly fresh samples with random upper status bits; the rest is
        // any status byte at all.
        if ($urandom_range(0, 9) < 7) s.status = {6'($urandom_range(0, 63)), 2'b11};
        else                          s.status = 8'($urandom_range(0, 255));
        s.ax = pick_raw();
        s.ay = pick_raw();
        s.az = pick_raw();
        s.gx = pick_raw();
        s.gy = pick_raw();
        s.gz = pick_raw();
        send_request(s, 1'b0, '0);
        sender_gap();
      end
    end

    smp.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/iss_pkg.sv
sv/iss_if.sv
sv/iss_scale.sv
sv/iss_remap.sv
sv/imu_sample_scale_and_remap_top.sv
verif/tb_top.sv
